/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define YCF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yaw filter check failed");

// next-cycle implication
`define YCF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yaw filter check failed");

`endif

/* rtl/ycf_pkg.sv */
// ----------------------------------------------------------------------------
// ycf_pkg
// Types, widths and constants of the yaw complementary filter.
// ----------------------------------------------------------------------------
package ycf_pkg;

   localparam int RATE_W     = 16;
   localparam int HEAD_W     = 16;
   localparam int STEP_W     = 17;
   localparam int YAW_W      = 16;
   localparam int WEIGHT_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam int PROD_W     = RATE_W + STEP_W + 1;
   localparam int RATE_SHIFT = 10;
   localparam int WEIGHT_SHIFT = 16;

   // floor division by 15625 as a reciprocal multiply, exact below 2^32
   localparam int                 RECIP_W     = 31;
   localparam int                 RECIP_SHIFT = 44;
   localparam logic [RECIP_W-1:0] RECIP_MUL   = 31'd1125899907;
   localparam logic [15:0]        DIV_ROUND   = 16'd15624;

   localparam logic [WEIGHT_W-1:0] MAG_WEIGHT_RST   = 16'd1311;
   localparam logic [STEP_W-1:0]   DEFAULT_STEP_RST = 17'd4000;
   localparam logic [STEP_W-1:0]   MAX_STEP_RST     = 17'd100000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAG_WEIGHT,
      CSR_DEFAULT_STEP,
      CSR_MAX_STEP
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_NORM,
      ST_DIV,
      ST_PRED,
      ST_ERR,
      ST_PROD,
      ST_UPD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_direct;
      logic mul;
      logic norm;
      logic div_step;
      logic pred;
      logic err;
      logic prod;
      logic upd;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic direct;
   } status_type;

endpackage

/* rtl/ycf_ifs.sv */
// ----------------------------------------------------------------------------
// ycf_ifs
// Request, response and register-write channels of the yaw filter.
// ----------------------------------------------------------------------------
interface ycf_req_if import ycf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic signed [RATE_W-1:0] turn_rate;
   logic [HEAD_W-1:0]        compass_heading;
   logic [STEP_W-1:0]        step_us;

   modport source (output valid, operation, turn_rate, compass_heading, step_us,
                   input ready);
   modport sink   (input valid, operation, turn_rate, compass_heading, step_us,
                   output ready);
endinterface

interface ycf_rsp_if import ycf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [YAW_W-1:0] yaw_out;

   modport source (output valid, yaw_out, input ready);
   modport sink   (input valid, yaw_out, output ready);
endinterface

interface ycf_csr_if import ycf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/yaw_complementary_filter_top.sv */
// ----------------------------------------------------------------------------
// yaw_complementary_filter_top
// Fixed-point yaw complementary filter with heading wrap-around.
// ----------------------------------------------------------------------------
// One request word is processed at a time. A reset word, and the first update
// after block reset, load the heading directly and go on to the response
// register; an update runs, for any ANGLE_FRAC_BITS, the fixed chain of
// product, normalize, reciprocal divide by 15625, predict, error, correction
// product and update before it loads the response register. The response
// register lets a new request in while the previous word waits on rsp_bus; a
// word that finishes while that response still waits holds in the last stage
// until rsp_bus takes it. Register writes are taken every cycle and belong in
// gaps where no word is in flight.
module yaw_complementary_filter_top import ycf_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic       clock,
   input  logic       reset,
   ycf_req_if.sink    req_bus,
   ycf_rsp_if.source  rsp_bus,
   ycf_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;

   ycf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ycf_dpath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_operation       (req_bus.operation),
      .req_turn_rate       (req_bus.turn_rate),
      .req_compass_heading (req_bus.compass_heading),
      .req_step_us         (req_bus.step_us),
      .rsp_yaw_out         (rsp_bus.yaw_out),
      .csr_valid           (csr_bus.valid),
      .csr_ready           (csr_bus.ready),
      .csr_index           (csr_bus.index),
      .csr_data            (csr_bus.data),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

/* rtl/ycf_ctrl.sv */
// ----------------------------------------------------------------------------
// ycf_ctrl
// Sequencer of the filter: steps the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module ycf_ctrl import ycf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type      state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.direct) begin
               cmd.load_direct = 1'b1;
               state_in        = ST_SEND;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_PRED;
         end
         ST_PRED: begin
            cmd.pred = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/ycf_dpath.sv */
// ----------------------------------------------------------------------------
// ycf_dpath
// Filter datapath: registers, gyro integration, reciprocal divider, correction.
// ----------------------------------------------------------------------------
module ycf_dpath import ycf_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_operation,
   input  logic signed [RATE_W-1:0] req_turn_rate,
   input  logic [HEAD_W-1:0]        req_compass_heading,
   input  logic [STEP_W-1:0]        req_step_us,
   output logic [YAW_W-1:0]         rsp_yaw_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  cmd_type                  cmd,
   output status_type               status
);

   localparam int FULL  = 360 << ANGLE_FRAC_BITS;
   localparam int HALF  = 180 << ANGLE_FRAC_BITS;
   localparam int AW    = $clog2(FULL);
   localparam int HW    = (AW > HEAD_W) ? AW : HEAD_W;
   localparam int RED_STEPS = (ANGLE_FRAC_BITS >= 8) ? 0 : 8 - ANGLE_FRAC_BITS;
   localparam int SHR   = RATE_SHIFT - ANGLE_FRAC_BITS;
   localparam int UW    = 23 + ANGLE_FRAC_BITS;
   localparam int QW    = UW - 13;
   localparam int QPW   = UW + RECIP_W;
   localparam int SW    = QW + 3;
   localparam int EW    = AW + 2;
   localparam int CPW   = EW + WEIGHT_W + 1;

   logic [WEIGHT_W-1:0]        weight_ff;
   logic [STEP_W-1:0]          dflt_step_ff;
   logic [STEP_W-1:0]          max_step_ff;
   logic                       started_ff;
   logic [AW-1:0]              fused_ff, fused_in;
   logic                       op_ff;
   logic signed [RATE_W-1:0]   rate_ff;
   logic [AW-1:0]              heading_ff, heading_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [PROD_W-1:0]   mprod_ff;
   logic                       neg_ff;
   logic [UW-1:0]              num_ff;
   logic [QW-1:0]              quo_ff, quo_in;
   logic [AW-1:0]              pred_ff, pred_in;
   logic signed [EW-1:0]       err_ff, err_in;
   logic signed [CPW-1:0]      cprod_ff;
   logic [YAW_W-1:0]           yaw_ff;
   logic [UW-1:0]              norm_u;
   logic                       norm_neg;

   assign csr_ready     = 1'b1;
   assign status.direct = op_ff | ~started_ff;
   assign rsp_yaw_out   = yaw_ff;

   // heading reduction and step selection
   always_comb begin
      logic [HW-1:0] h;
      h = HW'(req_compass_heading);
      for (int j = RED_STEPS - 1; j >= 0; j--) begin
         if (32'(h) >= (FULL << j)) begin
            h = h - HW'(FULL << j);
         end
      end
      heading_in = AW'(h);
      if (req_step_us == '0 || req_step_us > max_step_ff) begin
         step_in = dflt_step_ff;
      end else begin
         step_in = req_step_us;
      end
   end

   // floor split: negative values divide as ceil of magnitude
   always_comb begin
      logic signed [PROD_W-1:0] t;
      logic signed [PROD_W-1:0] tneg;
      logic [PROD_W-1:0]        mag;
      t    = mprod_ff >>> SHR;
      tneg = -t;
      norm_neg = t[PROD_W-1];
      if (norm_neg) begin
         mag = $unsigned(tneg) + PROD_W'(DIV_ROUND);
      end else begin
         mag = $unsigned(t);
      end
      norm_u = mag[UW-1:0];
   end

   // quotient of the increment magnitude by 15625
   always_comb begin
      logic [QPW-1:0] qp;
      qp     = QPW'(num_ff) * QPW'(RECIP_MUL);
      quo_in = qp[QPW-1:RECIP_SHIFT];
   end

   // integrate and wrap
   always_comb begin
      logic signed [QW:0]    q;
      logic signed [SW-1:0]  sum;
      logic signed [SW-1:0]  cand;
      if (neg_ff) begin
         q = -$signed({1'b0, quo_ff});
      end else begin
         q = $signed({1'b0, quo_ff});
      end
      sum     = $signed(SW'(fused_ff)) + SW'(q);
      pred_in = '0;
      for (int k = -2; k <= 2; k++) begin
         cand = sum + SW'(k * FULL);
         if (cand >= 0 && cand < FULL) begin
            pred_in = AW'(cand);
         end
      end
   end

   // wrap-aware error
   always_comb begin
      logic signed [EW-1:0] e;
      e = $signed(EW'(heading_ff)) - $signed(EW'(pred_ff));
      if (e > HALF) begin
         err_in = e - EW'(FULL);
      end else if (e < -HALF) begin
         err_in = e + EW'(FULL);
      end else begin
         err_in = e;
      end
   end

   // apply correction and wrap
   always_comb begin
      logic signed [CPW-1:0] cs;
      logic signed [EW-1:0]  v;
      cs = cprod_ff >>> WEIGHT_SHIFT;
      v  = $signed(EW'(pred_ff)) + EW'(cs);
      if (v < 0) begin
         v = v + EW'(FULL);
      end else if (v >= FULL) begin
         v = v - EW'(FULL);
      end
      fused_in = AW'(v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= MAG_WEIGHT_RST;
         dflt_step_ff <= DEFAULT_STEP_RST;
         max_step_ff  <= MAX_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAG_WEIGHT:   weight_ff    <= csr_data[WEIGHT_W-1:0];
            CSR_DEFAULT_STEP: dflt_step_ff <= csr_data[STEP_W-1:0];
            CSR_MAX_STEP:     max_step_ff  <= csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         fused_ff   <= '0;
      end else if (cmd.load_direct) begin
         started_ff <= 1'b1;
         fused_ff   <= heading_ff;
      end else if (cmd.upd) begin
         fused_ff   <= fused_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         rate_ff    <= req_turn_rate;
         heading_ff <= heading_in;
         step_ff    <= step_in;
      end
      if (cmd.mul) begin
         mprod_ff <= PROD_W'(rate_ff) * PROD_W'($signed({1'b0, step_ff}));
      end
      if (cmd.norm) begin
         neg_ff <= norm_neg;
         num_ff <= norm_u;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
      end
      if (cmd.pred) begin
         pred_ff <= pred_in;
      end
      if (cmd.err) begin
         err_ff <= err_in;
      end
      if (cmd.prod) begin
         cprod_ff <= CPW'(err_ff) * CPW'($signed({1'b0, weight_ff}));
      end
      if (cmd.send) begin
         yaw_ff <= YAW_W'(fused_ff);
      end
   end

endmodule

/* rtl/ycf_chk.sv */
// ----------------------------------------------------------------------------
// ycf_chk
// Port-level checks of the yaw filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ycf_chk import ycf_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [YAW_W-1:0] yaw_out
);

   localparam int FULL = 360 << ANGLE_FRAC_BITS;

   `YCF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `YCF_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(yaw_out))
   `YCF_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `YCF_ASSERT_IMP(a_yaw_range, clock, reset, rsp_valid, (ANGLE_FRAC_BITS > 7) || (32'(yaw_out) < FULL))

endmodule

bind yaw_complementary_filter_top ycf_chk #(
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_ycf_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .yaw_out   (rsp_bus.yaw_out)
);
